// ----- rtl/gpu_command_port_status_assert.svh -----
// Assertion macros for the GPU command port and status block.
// Used by rtl/gpu_command_port_status.sv; the macros expect clk and rst in scope.
`ifndef GPU_COMMAND_PORT_STATUS_ASSERT_SVH
`define GPU_COMMAND_PORT_STATUS_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define GCPS_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define GCPS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);
`else
`define GCPS_ASSERT_IMP(label, pre, post, msg)
`define GCPS_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ----- rtl/gcps_pkg.sv -----
// Package for the GPU command port and status block: request kinds, opcodes,
// status bit positions, reset values and the packet length table. No dependencies.
package gcps_pkg;

  // Field widths of a request and of the word counter
  localparam int KIND_W = 2;
  localparam int WORD_W = 32;
  localparam int OP_W   = 8;
  localparam int LEN_W  = 4;
  localparam int WL_W   = 31;

  // Request kinds; every other code is a status read
  localparam logic [KIND_W-1:0] KIND_GP0 = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GP1 = 2'd1;

  // Command port (GP0) opcodes
  localparam logic [OP_W-1:0] GP0_NOP            = 8'h00;
  localparam logic [OP_W-1:0] GP0_CLEAR_CACHE    = 8'h01;
  localparam logic [OP_W-1:0] GP0_FILL_RECT      = 8'h02;
  localparam logic [OP_W-1:0] GP0_RSVD_03        = 8'h03;
  localparam logic [OP_W-1:0] GP0_RSVD_08        = 8'h08;
  localparam logic [OP_W-1:0] GP0_QUAD_MONO      = 8'h28;
  localparam logic [OP_W-1:0] GP0_QUAD_TEX       = 8'h2c;
  localparam logic [OP_W-1:0] GP0_TRI_SHADED     = 8'h30;
  localparam logic [OP_W-1:0] GP0_QUAD_SHADED    = 8'h38;
  localparam logic [OP_W-1:0] GP0_COPY_TO_VRAM   = 8'ha0;
  localparam logic [OP_W-1:0] GP0_COPY_FROM_VRAM = 8'hc0;
  localparam logic [OP_W-1:0] GP0_DRAW_MODE      = 8'he1;
  localparam logic [OP_W-1:0] GP0_TEX_WINDOW     = 8'he2;
  localparam logic [OP_W-1:0] GP0_AREA_TL        = 8'he3;
  localparam logic [OP_W-1:0] GP0_AREA_BR        = 8'he4;
  localparam logic [OP_W-1:0] GP0_DRAW_OFFSET    = 8'he5;
  localparam logic [OP_W-1:0] GP0_MASK_BIT       = 8'he6;

  // Control port (GP1) opcodes
  localparam logic [OP_W-1:0] GP1_RESET       = 8'h00;
  localparam logic [OP_W-1:0] GP1_CLEAR_FIFO  = 8'h01;
  localparam logic [OP_W-1:0] GP1_IRQ_ACK     = 8'h02;
  localparam logic [OP_W-1:0] GP1_DISPLAY_EN  = 8'h03;
  localparam logic [OP_W-1:0] GP1_DMA_DIR     = 8'h04;
  localparam logic [OP_W-1:0] GP1_DISP_START  = 8'h05;
  localparam logic [OP_W-1:0] GP1_H_RANGE     = 8'h06;
  localparam logic [OP_W-1:0] GP1_V_RANGE     = 8'h07;
  localparam logic [OP_W-1:0] GP1_DISP_MODE   = 8'h08;

  // DMA direction codes
  localparam logic [1:0] DIR_OFF      = 2'd0;
  localparam logic [1:0] DIR_FIFO     = 2'd1;
  localparam logic [1:0] DIR_TO_GPU   = 2'd2;
  localparam logic [1:0] DIR_FROM_GPU = 2'd3;

  // Status register bit positions
  localparam int ST_MASK_SET  = 11;
  localparam int ST_DITHER    = 13;
  localparam int ST_INTERLACE = 14;
  localparam int ST_DRAW_DISP = 15;
  localparam int ST_HRES2     = 16;
  localparam int ST_READ_HIDE = 19;
  localparam int ST_DISP_OFF  = 23;
  localparam int ST_IRQ       = 24;
  localparam int ST_DREQ      = 25;
  localparam int ST_CMDOK     = 26;
  localparam int ST_VRDY      = 27;
  localparam int ST_BLKOK     = 28;
  localparam int ST_DIR_LO    = 29;

  // Reset values
  localparam logic [31:0] STATUS_RESET = 32'h1400_0000;
  localparam logic [12:0] HRANGE_RESET = 13'd2560;
  localparam logic [10:0] VRANGE_RESET = 11'd240;

  // Number of words in a command port packet; zero marks an opcode not handled
  function automatic logic [LEN_W-1:0] packet_length(input logic [OP_W-1:0] op);
    logic [LEN_W-1:0] len;
    len = '0;
    case (op) inside
      GP0_NOP, GP0_CLEAR_CACHE, GP0_RSVD_03, GP0_RSVD_08,
      GP0_DRAW_MODE, GP0_TEX_WINDOW, GP0_AREA_TL, GP0_AREA_BR,
      GP0_DRAW_OFFSET, GP0_MASK_BIT:               len = 4'd1;
      GP0_FILL_RECT, GP0_COPY_TO_VRAM,
      GP0_COPY_FROM_VRAM:                          len = 4'd3;
      GP0_QUAD_MONO:                               len = 4'd5;
      GP0_TRI_SHADED:                              len = 4'd6;
      GP0_QUAD_SHADED:                             len = 4'd8;
      GP0_QUAD_TEX:                                len = 4'd9;
      default:                                     len = '0;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/gpu_command_port_status.sv -----
// Top level of the GPU command port (GP0), control port (GP1) and status register.
// Depends on rtl/gcps_pkg.sv and the macros in gpu_command_port_status_assert.svh.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------------
//   request | in_valid / in_ready  | kind, word
//   result  | out_valid / out_ready| status_word, area_top_left, area_bottom_right,
//           |                      | draw_offset, tex_window, display_start,
//           |                      | h_range, v_range, unknown_command
//
// One request a cycle while the result register is not stalled; a request passes through
// the input register and then the result register. The held request is decoded against
// the stored state and lands in the result register together with the updated state.
// A stalled result register holds the input register, and in_ready falls only when
// both are full. Synchronous reset clears the state, but for hdr_op, to its power-on values at once.
`include "gpu_command_port_status_assert.svh"

module gpu_command_port_status (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gcps_pkg::KIND_W-1:0]  kind,
  input  logic [gcps_pkg::WORD_W-1:0]  word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [31:0]                  status_word,
  output logic [18:0]                  area_top_left,
  output logic [18:0]                  area_bottom_right,
  output logic [22:0]                  draw_offset,
  output logic [19:0]                  tex_window,
  output logic [19:0]                  display_start,
  output logic signed [12:0]           h_range,
  output logic signed [10:0]           v_range,
  output logic                         unknown_command
);

  import gcps_pkg::*;

  // Input register
  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic [WORD_W-1:0] s1_word;
  logic              s1_advance;

  // Architectural state
  logic [31:0]     status;
  logic [WL_W-1:0] words_left;
  logic            copy_mode;
  logic [OP_W-1:0] hdr_op;
  logic [18:0]     area_tl;
  logic [18:0]     area_br;
  logic [22:0]     offset;
  logic [19:0]     texwin;
  logic [19:0]     disp_start;
  logic [12:0]     hrange;
  logic [10:0]     vrange;

  logic [31:0]     status_next;
  logic [WL_W-1:0] words_left_next;
  logic            copy_mode_next;
  logic [OP_W-1:0] hdr_op_next;
  logic [18:0]     area_tl_next;
  logic [18:0]     area_br_next;
  logic [22:0]     offset_next;
  logic [19:0]     texwin_next;
  logic [19:0]     disp_start_next;
  logic [12:0]     hrange_next;
  logic [10:0]     vrange_next;
  logic            bad;

  // Decode helpers
  logic [OP_W-1:0]  op;
  logic [23:0]      arg;
  logic             starting;
  logic [LEN_W-1:0] pkt_len;
  logic [OP_W-1:0]  eff_op;
  logic [WL_W-1:0]  left_base;
  logic [WL_W-1:0]  left_dec;
  logic [31:0]      copy_area;
  logic [32:0]      copy_round;
  logic [WL_W-1:0]  copy_count;

  // Handshake: the input register moves on whenever the result register is free
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_kind <= kind;
      s1_word <= word;
    end
  end

  // Field decode of the held request
  assign op        = s1_word[31:24];
  assign arg       = s1_word[23:0];
  assign starting  = (words_left == '0);
  assign pkt_len   = packet_length(op);
  assign eff_op    = starting ? op : hdr_op;
  assign left_base = starting ? WL_W'(pkt_len) : words_left;
  assign left_dec  = left_base - WL_W'(1);

  // Copy length: half the pixel count, rounded up
  assign copy_area  = 32'(s1_word[15:0]) * 32'(s1_word[31:16]);
  assign copy_round = {1'b0, copy_area} + 33'd1;
  assign copy_count = copy_round[WL_W:1];

  // Next state for one request
  always_comb begin
    status_next     = status;
    words_left_next = words_left;
    copy_mode_next  = copy_mode;
    hdr_op_next     = hdr_op;
    area_tl_next    = area_tl;
    area_br_next    = area_br;
    offset_next     = offset;
    texwin_next     = texwin;
    disp_start_next = disp_start;
    hrange_next     = hrange;
    vrange_next     = vrange;
    bad             = 1'b0;

    case (s1_kind)
      KIND_GP0: begin
        if (starting && pkt_len == '0) begin
          // Opcode with no packet length: the word is dropped
          bad = 1'b1;
        end else begin
          words_left_next = left_dec;
          if (starting) begin
            status_next[ST_BLKOK] = 1'b1;
            status_next[ST_CMDOK] = 1'b0;
            hdr_op_next           = op;
          end
          if (!copy_mode) begin
            // Last word of a packet runs the command
            if (left_dec == '0) begin
              status_next[ST_BLKOK] = 1'b1;
              unique case (eff_op) inside
                GP0_DRAW_MODE: begin
                  status_next[10:0]         = s1_word[10:0];
                  status_next[ST_DRAW_DISP] = s1_word[11];
                  status_next[ST_DITHER]    = s1_word[13];
                end
                GP0_TEX_WINDOW:  texwin_next  = s1_word[19:0];
                GP0_AREA_TL:     area_tl_next = s1_word[18:0];
                GP0_AREA_BR:     area_br_next = s1_word[18:0];
                GP0_DRAW_OFFSET: offset_next  = s1_word[22:0];
                GP0_MASK_BIT:    status_next[ST_MASK_SET+1:ST_MASK_SET] = s1_word[1:0];
                GP0_COPY_TO_VRAM: begin
                  words_left_next = copy_count;
                  copy_mode_next  = (copy_count != '0);
                end
                GP0_COPY_FROM_VRAM: begin
                  status_next[ST_VRDY] = 1'b1;
                  words_left_next      = copy_count;
                  copy_mode_next       = (copy_count != '0);
                end
                GP0_NOP, GP0_CLEAR_CACHE, GP0_FILL_RECT, GP0_QUAD_MONO,
                GP0_QUAD_TEX, GP0_TRI_SHADED, GP0_QUAD_SHADED: ;
                default: bad = 1'b1;
              endcase
              status_next[ST_CMDOK] = 1'b1;
            end
          end else if (left_dec == '0) begin
            // Copy data is swallowed; the last word ends the copy
            copy_mode_next = 1'b0;
          end
        end
      end

      KIND_GP1: begin
        unique case (op)
          GP1_RESET: begin
            words_left_next              = '0;
            copy_mode_next               = 1'b0;
            status_next[ST_IRQ]          = 1'b0;
            status_next[ST_DISP_OFF]     = 1'b1;
            status_next[ST_DIR_LO+1:ST_DIR_LO] = DIR_OFF;
            status_next[ST_DREQ]         = 1'b0;
            disp_start_next              = '0;
            hrange_next                  = HRANGE_RESET;
            vrange_next                  = VRANGE_RESET;
            status_next[22:17]           = '0;
            status_next[ST_HRES2]        = 1'b0;
            status_next[ST_INTERLACE]    = 1'b0;
            status_next[ST_DITHER]       = 1'b1;
          end
          GP1_CLEAR_FIFO: begin
            words_left_next = '0;
            copy_mode_next  = 1'b0;
          end
          GP1_IRQ_ACK:    status_next[ST_IRQ]      = 1'b0;
          GP1_DISPLAY_EN: status_next[ST_DISP_OFF] = arg[0];
          GP1_DMA_DIR: begin
            status_next[ST_DIR_LO+1:ST_DIR_LO] = arg[1:0];
            // A packet in collection never has an empty total, so FIFO mode holds
            unique case (arg[1:0])
              DIR_OFF:      status_next[ST_DREQ] = 1'b0;
              DIR_FIFO:     status_next[ST_DREQ] = status[ST_DREQ];
              DIR_TO_GPU:   status_next[ST_DREQ] = status[ST_BLKOK];
              DIR_FROM_GPU: status_next[ST_DREQ] = status[ST_VRDY];
              default:      status_next[ST_DREQ] = status[ST_DREQ];
            endcase
          end
          GP1_DISP_START: disp_start_next = {arg[18:10], 1'b0, arg[9:0]};
          GP1_H_RANGE:    hrange_next = {1'b0, arg[23:12]} - {1'b0, arg[11:0]};
          GP1_V_RANGE:    vrange_next = {1'b0, arg[19:10]} - {1'b0, arg[9:0]};
          GP1_DISP_MODE: begin
            status_next[22:17]        = arg[5:0];
            status_next[ST_HRES2]     = arg[6];
            status_next[ST_INTERLACE] = arg[7];
            if (!arg[5]) begin
              status_next[ST_DITHER] = 1'b1;
            end
          end
          default: bad = 1'b1;
        endcase
      end

      default: ;
    endcase
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      status     <= STATUS_RESET;
      words_left <= '0;
      copy_mode  <= 1'b0;
      area_tl    <= '0;
      area_br    <= '0;
      offset     <= '0;
      texwin     <= '0;
      disp_start <= '0;
      hrange     <= HRANGE_RESET;
      vrange     <= VRANGE_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (s1_advance) begin
        status     <= status_next;
        words_left <= words_left_next;
        copy_mode  <= copy_mode_next;
        area_tl    <= area_tl_next;
        area_br    <= area_br_next;
        offset     <= offset_next;
        texwin     <= texwin_next;
        disp_start <= disp_start_next;
        hrange     <= hrange_next;
        vrange     <= vrange_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
    if (s1_advance) begin
      hdr_op            <= hdr_op_next;
      status_word       <= status_next & ~(32'd1 << ST_READ_HIDE);
      area_top_left     <= area_tl_next;
      area_bottom_right <= area_br_next;
      draw_offset       <= offset_next;
      tex_window        <= texwin_next;
      display_start     <= disp_start_next;
      h_range           <= hrange_next;
      v_range           <= vrange_next;
      unknown_command   <= bad;
    end
  end

  // Checks on the packet counter and the command decode
  `GCPS_ASSERT_IMP(a_copy_has_words, copy_mode, words_left != '0, "copy mode with no words left")
  `GCPS_ASSERT_NEXT(a_multi_word_header, s1_advance && s1_kind == KIND_GP0 && starting && pkt_len > 4'd1, words_left != '0 && !copy_mode, "packet header did not start collection")
  `GCPS_ASSERT_NEXT(a_read_never_bad, s1_advance && s1_kind != KIND_GP0 && s1_kind != KIND_GP1, out_valid && !unknown_command, "status read flagged as unknown")
  `GCPS_ASSERT_NEXT(a_gp1_reset, s1_advance && s1_kind == KIND_GP1 && op == GP1_RESET, words_left == '0 && !copy_mode && status[ST_DISP_OFF], "control reset left packet state")

endmodule

// ----- dv/gpu_command_port_status_checker.sv -----
`timescale 1ns / 100ps
// Checker for the GPU command port and status block: watches both channels, keeps its own
// copy of the port state and compares every result against the predicted registers.
// Depends on rtl/gcps_pkg.sv for the opcodes, direction codes and status bit positions.
module gpu_command_port_status_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] status_word,
  input  logic [18:0] area_top_left,
  input  logic [18:0] area_bottom_right,
  input  logic [22:0] draw_offset,
  input  logic [19:0] tex_window,
  input  logic [19:0] display_start,
  input  logic [12:0] h_range,
  input  logic [10:0] v_range,
  input  logic        unknown_command,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen,
  output int          flags_seen
);
  import gcps_pkg::*;

  localparam int PACKET_WORDS = 16;
  // Display ranges that a control port reset programs.
  localparam logic [23:0] RESET_H_SPAN = 24'h200 | ((24'h200 + 24'd2560) << 12);
  localparam logic [23:0] RESET_V_SPAN = 24'h10 | ((24'h10 + 24'd240) << 10);

  typedef enum logic [1:0] {
    MODE_COMMAND,
    MODE_TO_VRAM,
    MODE_FROM_VRAM
  } port_mode_e;

  // Register view carried by one result.
  typedef struct packed {
    logic [31:0] status;
    logic [18:0] area_tl;
    logic [18:0] area_br;
    logic [22:0] offset;
    logic [19:0] texwin;
    logic [19:0] dstart;
    logic [12:0] hrange;
    logic [10:0] vrange;
    logic        unknown;
  } snapshot_t;

  logic [31:0] status_r;
  port_mode_e  mode_r;
  logic [31:0] left_r;
  logic [31:0] total_r;
  logic [31:0] packet_r [PACKET_WORDS];
  logic [18:0] area_tl_r;
  logic [18:0] area_br_r;
  logic [22:0] offset_r;
  logic [19:0] texwin_r;
  logic [19:0] dstart_r;
  logic [12:0] hrange_r;
  logic [10:0] vrange_r;

  snapshot_t register_snapshots [$];

  // Number of words in a command port packet; zero for an opcode that is not handled.
  function automatic int words_in_packet(input logic [7:0] op);
    case (op)
      GP0_NOP, GP0_CLEAR_CACHE, GP0_RSVD_03, GP0_RSVD_08, GP0_DRAW_MODE,
      GP0_TEX_WINDOW, GP0_AREA_TL, GP0_AREA_BR, GP0_DRAW_OFFSET,
      GP0_MASK_BIT:                                          return 1;
      GP0_FILL_RECT, GP0_COPY_TO_VRAM, GP0_COPY_FROM_VRAM:  return 3;
      GP0_QUAD_MONO:                                         return 5;
      GP0_TRI_SHADED:                                        return 6;
      GP0_QUAD_SHADED:                                       return 8;
      GP0_QUAD_TEX:                                          return 9;
      default:                                               return 0;
    endcase
  endfunction

  task automatic clear_port_state();
    status_r  = STATUS_RESET;
    mode_r    = MODE_COMMAND;
    left_r    = '0;
    total_r   = '0;
    for (int i = 0; i < PACKET_WORDS; i++) packet_r[i] = '0;
    area_tl_r = '0;
    area_br_r = '0;
    offset_r  = '0;
    texwin_r  = '0;
    dstart_r  = '0;
    hrange_r  = HRANGE_RESET;
    vrange_r  = VRANGE_RESET;
  endtask

  // The DMA request bit follows the chosen direction.
  task automatic load_direction(input logic [1:0] dir);
    status_r[ST_DIR_LO +: 2] = dir;
    case (dir)
      DIR_OFF:    status_r[ST_DREQ] = 1'b0;
      DIR_FIFO: begin
        if (left_r != 0 && total_r == 0) status_r[ST_DREQ] = 1'b1;
      end
      DIR_TO_GPU: status_r[ST_DREQ] = status_r[ST_BLKOK];
      default:    status_r[ST_DREQ] = status_r[ST_VRDY];
    endcase
  endtask

  // Display mode loads bits 22 to 17, 16 and 14, and sets bit 13 when bit 5 is clear.
  task automatic load_display_mode(input logic [23:0] v);
    status_r[22:17]        = v[5:0];
    status_r[ST_HRES2]     = v[6];
    status_r[ST_INTERLACE] = v[7];
    if (!v[5]) status_r[ST_DITHER] = 1'b1;
  endtask

  task automatic load_ranges_h(input logic [23:0] v);
    hrange_r = {1'b0, v[23:12]} - {1'b0, v[11:0]};
  endtask

  task automatic load_ranges_v(input logic [23:0] v);
    vrange_r = {1'b0, v[19:10]} - {1'b0, v[9:0]};
  endtask

  task automatic drop_transfer();
    left_r  = '0;
    total_r = '0;
    mode_r  = MODE_COMMAND;
  endtask

  // A copy swallows ceil(w*h/2) further words; an empty copy stays in command mode.
  task automatic begin_copy(input port_mode_e mode, input logic [31:0] dims);
    logic [63:0] area;
    area    = {48'd0, dims[15:0]} * {48'd0, dims[31:16]};
    left_r  = 32'((area + 64'd1) >> 1);
    total_r = left_r;
    mode_r  = (left_r != 0) ? mode : MODE_COMMAND;
  endtask

  // Act on a complete packet; reserved opcodes are collected but rejected here.
  task automatic finish_packet(output logic rejected);
    logic [31:0] head;
    head     = packet_r[0];
    rejected = 1'b0;
    case (head[31:24])
      GP0_DRAW_MODE: begin
        status_r[10:0]         = head[10:0];
        status_r[ST_DRAW_DISP] = head[11];
        status_r[ST_DITHER]    = head[13];
      end
      GP0_TEX_WINDOW:  texwin_r = head[19:0];
      GP0_AREA_TL:     area_tl_r = head[18:0];
      GP0_AREA_BR:     area_br_r = head[18:0];
      GP0_DRAW_OFFSET: offset_r = head[22:0];
      GP0_MASK_BIT:    status_r[ST_MASK_SET +: 2] = head[1:0];
      GP0_COPY_TO_VRAM: begin_copy(MODE_TO_VRAM, packet_r[2]);
      GP0_COPY_FROM_VRAM: begin
        status_r[ST_VRDY] = 1'b1;
        begin_copy(MODE_FROM_VRAM, packet_r[2]);
      end
      GP0_NOP, GP0_CLEAR_CACHE, GP0_FILL_RECT, GP0_QUAD_MONO, GP0_QUAD_TEX,
      GP0_TRI_SHADED, GP0_QUAD_SHADED: ;
      default: rejected = 1'b1;
    endcase
  endtask

  // Command port write: start a packet, collect a word, or count down a copy.
  task automatic command_word(input logic [31:0] w, output logic rejected);
    int len;
    int pos;
    rejected = 1'b0;
    if (left_r == 0) begin
      len = words_in_packet(w[31:24]);
      if (len == 0) begin
        rejected = 1'b1;
      end else begin
        status_r[ST_BLKOK] = 1'b1;
        status_r[ST_CMDOK] = 1'b0;
        total_r = len;
        left_r  = len;
        mode_r  = MODE_COMMAND;
      end
    end
    if (!rejected) begin
      left_r = left_r - 1;
      if (mode_r == MODE_COMMAND) begin
        pos = total_r - left_r - 1;
        if (pos < PACKET_WORDS) packet_r[pos] = w;
        if (left_r == 0) begin
          total_r = '0;
          status_r[ST_BLKOK] = 1'b1;
          finish_packet(rejected);
          status_r[ST_CMDOK] = 1'b1;
        end
      end else if (left_r == 0) begin
        mode_r  = MODE_COMMAND;
        total_r = '0;
      end
    end
  endtask

  // Control port write: acts at once on status bits and display registers.
  task automatic control_word(input logic [31:0] w, output logic rejected);
    logic [23:0] v;
    v = w[23:0];
    rejected = 1'b0;
    case (w[31:24])
      GP1_RESET: begin
        drop_transfer();
        status_r[ST_IRQ]      = 1'b0;
        status_r[ST_DISP_OFF] = 1'b1;
        load_direction(DIR_OFF);
        dstart_r = '0;
        load_ranges_h(RESET_H_SPAN);
        load_ranges_v(RESET_V_SPAN);
        load_display_mode(24'd0);
      end
      GP1_CLEAR_FIFO: drop_transfer();
      GP1_IRQ_ACK:    status_r[ST_IRQ] = 1'b0;
      GP1_DISPLAY_EN: status_r[ST_DISP_OFF] = v[0];
      GP1_DMA_DIR:    load_direction(v[1:0]);
      GP1_DISP_START: dstart_r = {v[18:10], 1'b0, v[9:0]};
      GP1_H_RANGE:    load_ranges_h(v);
      GP1_V_RANGE:    load_ranges_v(v);
      GP1_DISP_MODE:  load_display_mode(v);
      default:        rejected = 1'b1;
    endcase
  endtask

  function automatic snapshot_t capture_registers(input logic rejected);
    snapshot_t s;
    s.status = status_r;
    s.status[ST_READ_HIDE] = 1'b0;
    s.area_tl = area_tl_r;
    s.area_br = area_br_r;
    s.offset  = offset_r;
    s.texwin  = texwin_r;
    s.dstart  = dstart_r;
    s.hrange  = hrange_r;
    s.vrange  = vrange_r;
    s.unknown = rejected;
    return s;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("%0t: %s is 0x%0h, predicted 0x%0h", $time, what, got, want);
  endtask

  // Results are compared first, then the accepted request advances the prediction.
  always @(posedge clk) begin : track
    snapshot_t want;
    logic      rejected;
    if (rst) begin
      clear_port_state();
      register_snapshots.delete();
      mismatches   = 0;
      results_seen = 0;
      flags_seen   = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (register_snapshots.size() == 0) begin
          note_mismatch("result with no request waiting", status_word, '0);
        end else begin
          want = register_snapshots.pop_front();
          if (status_word !== want.status)
            note_mismatch("status_word", status_word, want.status);
          if (area_top_left !== want.area_tl)
            note_mismatch("area_top_left", {13'd0, area_top_left}, {13'd0, want.area_tl});
          if (area_bottom_right !== want.area_br)
            note_mismatch("area_bottom_right", {13'd0, area_bottom_right},
                          {13'd0, want.area_br});
          if (draw_offset !== want.offset)
            note_mismatch("draw_offset", {9'd0, draw_offset}, {9'd0, want.offset});
          if (tex_window !== want.texwin)
            note_mismatch("tex_window", {12'd0, tex_window}, {12'd0, want.texwin});
          if (display_start !== want.dstart)
            note_mismatch("display_start", {12'd0, display_start}, {12'd0, want.dstart});
          if (h_range !== want.hrange)
            note_mismatch("h_range", {19'd0, h_range}, {19'd0, want.hrange});
          if (v_range !== want.vrange)
            note_mismatch("v_range", {21'd0, v_range}, {21'd0, want.vrange});
          if (unknown_command !== want.unknown)
            note_mismatch("unknown_command", {31'd0, unknown_command}, {31'd0, want.unknown});
        end
      end
      if (in_valid && in_ready) begin
        rejected = 1'b0;
        if (kind == KIND_GP0) command_word(word, rejected);
        else if (kind == KIND_GP1) control_word(word, rejected);
        if (rejected) flags_seen++;
        register_snapshots.push_back(capture_registers(rejected));
      end
      outstanding <= register_snapshots.size();
    end
  end

endmodule

// ----- dv/gpu_command_port_status_test.sv -----
`timescale 1ns / 100ps
// Testbench top for gpu_command_port_status: makes bus requests and result back-pressure,
// and gives the verdict. Depends on rtl/gcps_pkg.sv, the block and the checker beside it.
module gpu_command_port_status_test;
  import gcps_pkg::*;

  // Request kinds that only read the status register.
  localparam logic [KIND_W-1:0] KIND_STATUS     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STATUS_ALT = 2'd3;
  // An opcode that neither port handles.
  localparam logic [OP_W-1:0]   OP_UNHANDLED    = 8'hff;

  localparam int RANDOM_REQUESTS = 600;
  localparam int HOLD_CYCLES     = 80;
  localparam int IDLE_LIMIT      = 1000;
  localparam int DRAIN_CYCLES    = 8;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [KIND_W-1:0]  kind;
  logic [WORD_W-1:0]  word;
  logic               out_valid;
  logic               out_ready;
  logic [31:0]        status_word;
  logic [18:0]        area_top_left;
  logic [18:0]        area_bottom_right;
  logic [22:0]        draw_offset;
  logic [19:0]        tex_window;
  logic [19:0]        display_start;
  logic signed [12:0] h_range;
  logic signed [10:0] v_range;
  logic               unknown_command;

  int mismatches;
  int outstanding;
  int results_seen;
  int flags_seen;
  int requests_sent = 0;
  int quiet_cycles  = 0;
  bit idle_enable   = 1'b1;
  bit hold_results  = 1'b0;

  gpu_command_port_status u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .kind              (kind),
    .word              (word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status_word       (status_word),
    .area_top_left     (area_top_left),
    .area_bottom_right (area_bottom_right),
    .draw_offset       (draw_offset),
    .tex_window        (tex_window),
    .display_start     (display_start),
    .h_range           (h_range),
    .v_range           (v_range),
    .unknown_command   (unknown_command)
  );

  gpu_command_port_status_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .kind              (kind),
    .word              (word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status_word       (status_word),
    .area_top_left     (area_top_left),
    .area_bottom_right (area_bottom_right),
    .draw_offset       (draw_offset),
    .tex_window        (tex_window),
    .display_start     (display_start),
    .h_range           (h_range),
    .v_range           (v_range),
    .unknown_command   (unknown_command),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .results_seen      (results_seen),
    .flags_seen        (flags_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: too long without any request or result being taken ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("gpu_command_port_status verification failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when the stimulus asks for it.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= !(idle_enable && $urandom_range(0, 99) < 8);
    end
  end

  // Offer one request, with an occasional gap first, and wait until it is taken.
  // Valid is only lowered inside a gap, so back-to-back requests keep it high.
  task automatic send_request(input logic [KIND_W-1:0] k, input logic [WORD_W-1:0] w);
    while (idle_enable && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    word     <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // A command port packet with random body; a copy carries its size in the third word.
  // A non-zero cut stops the packet after that many words.
  task automatic send_packet(input logic [OP_W-1:0] op, input logic [31:0] dims,
                             input int cut);
    logic [23:0] low;
    int          len;
    low = 24'($urandom);
    len = int'(packet_length(op));
    send_request(KIND_GP0, {op, low});
    for (int i = 1; i < len && i != cut; i++) begin
      if (i == 2 && (op == GP0_COPY_TO_VRAM || op == GP0_COPY_FROM_VRAM))
        send_request(KIND_GP0, dims);
      else
        send_request(KIND_GP0, $urandom);
    end
  endtask

  // Abandon a transfer part-way through with a FIFO clear or a full reset.
  task automatic abort_transfer();
    logic [23:0] low;
    low = 24'($urandom);
    send_request(KIND_GP1, {($urandom_range(0, 3) == 0) ? GP1_RESET : GP1_CLEAR_FIFO, low});
  endtask

  // Copy request with mostly small sizes; a broken copy stops short of its data.
  task automatic send_copy(input bit broken);
    logic [OP_W-1:0] op;
    logic [15:0]     w;
    logic [15:0]     h;
    int              words;
    op = $urandom_range(0, 1) ? GP0_COPY_TO_VRAM : GP0_COPY_FROM_VRAM;
    case ($urandom_range(0, 9))
      0: begin
        w = 16'($urandom);
        h = '0;
      end
      1: begin
        w = '0;
        h = 16'($urandom);
      end
      default: begin
        w = 16'($urandom_range(1, 6));
        h = 16'($urandom_range(1, 6));
      end
    endcase
    words = (int'(w) * int'(h) + 1) / 2;
    send_packet(op, {h, w}, 0);
    if (broken && words > 0) words = int'($urandom_range(0, words - 1));
    for (int i = 0; i < words; i++) send_request(KIND_GP0, $urandom);
    if (broken) abort_transfer();
  endtask

  // A drawing or reserved packet; sometimes cut short and cleared.
  task automatic send_shape(input bit broken);
    logic [OP_W-1:0] op;
    int              len;
    case ($urandom_range(0, 8))
      0:       op = GP0_NOP;
      1:       op = GP0_CLEAR_CACHE;
      2:       op = GP0_FILL_RECT;
      3:       op = GP0_RSVD_03;
      4:       op = GP0_RSVD_08;
      5:       op = GP0_QUAD_MONO;
      6:       op = GP0_QUAD_TEX;
      7:       op = GP0_TRI_SHADED;
      default: op = GP0_QUAD_SHADED;
    endcase
    len = int'(packet_length(op));
    if (broken && len > 1) begin
      send_packet(op, $urandom, int'($urandom_range(1, len - 1)));
      abort_transfer();
    end else begin
      send_packet(op, $urandom, 0);
    end
  endtask

  initial begin : stimulus
    int          target;
    int          pick;
    bit          held;
    bit          paused;
    logic [23:0] low;
    logic [OP_W-1:0] op;
    held   = 1'b0;
    paused = 1'b0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    kind     <= KIND_GP0;
    word     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: every environment command at full width, unknown and reserved opcodes,
    // display registers at their extremes, a short copy and an empty one, then reset.
    send_request(KIND_STATUS, 32'hffff_ffff);
    send_request(KIND_GP0, {GP0_DRAW_MODE, 24'hff_ffff});
    send_request(KIND_GP0, {GP0_TEX_WINDOW, 24'hff_ffff});
    send_request(KIND_GP0, {GP0_AREA_TL, 24'hff_ffff});
    send_request(KIND_GP0, {GP0_AREA_BR, 24'hff_ffff});
    send_request(KIND_GP0, {GP0_DRAW_OFFSET, 24'hff_ffff});
    send_request(KIND_GP0, {GP0_MASK_BIT, 24'hff_ffff});
    send_request(KIND_GP0, {OP_UNHANDLED, 24'hff_ffff});
    send_request(KIND_GP0, {GP0_RSVD_03, 24'h00_0000});
    send_request(KIND_GP1, {GP1_DISP_START, 24'hff_ffff});
    send_request(KIND_GP1, {GP1_H_RANGE, 24'h000_fff});
    send_request(KIND_GP1, {GP1_V_RANGE, 24'h00_03ff});
    send_request(KIND_GP1, {GP1_H_RANGE, 24'hfff_000});
    send_request(KIND_GP1, {GP1_V_RANGE, 24'h0f_fc00});
    send_request(KIND_GP1, {GP1_DISP_MODE, 24'hff_ffff});
    send_request(KIND_GP1, {GP1_DMA_DIR, 22'd0, DIR_TO_GPU});
    send_request(KIND_GP1, {OP_UNHANDLED, 24'h00_0000});
    send_request(KIND_GP0, {GP0_COPY_TO_VRAM, 24'h00_0000});
    send_request(KIND_GP0, 32'h0000_0000);
    send_request(KIND_GP0, {16'd1, 16'd1});
    send_request(KIND_GP0, {GP0_DRAW_MODE, 24'h00_0000});
    send_request(KIND_GP0, {GP0_COPY_FROM_VRAM, 24'h00_0000});
    send_request(KIND_GP0, 32'h0000_0000);
    send_request(KIND_GP0, {16'hffff, 16'd0});
    send_request(KIND_GP1, {GP1_RESET, 24'h00_0000});
    send_request(KIND_STATUS_ALT, 32'h0000_0000);

    // Random mix of well-formed packets, copies and control writes, with some noise.
    target = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < target) begin
      idle_enable = !(requests_sent >= 250 && requests_sent < 350);
      if (!held && requests_sent >= 200) begin
        held = 1'b1;
        hold_results = 1'b1;
      end
      if (!paused && requests_sent >= 420) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      low  = 24'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        op = OP_W'($urandom_range(GP0_DRAW_MODE, GP0_MASK_BIT));
        send_request(KIND_GP0, {op, low});
      end else if (pick < 48) begin
        send_shape($urandom_range(0, 9) == 0);
      end else if (pick < 60) begin
        send_copy($urandom_range(0, 6) == 0);
      end else if (pick < 85) begin
        if ($urandom_range(0, 19) == 0) op = GP1_RESET;
        else op = OP_W'($urandom_range(GP1_CLEAR_FIFO, GP1_DISP_MODE));
        send_request(KIND_GP1, {op, low});
      end else if (pick < 90) begin
        op = OP_W'($urandom_range(GP1_DISP_MODE + 1, OP_UNHANDLED));
        send_request(KIND_GP1, {op, low});
      end else if (pick < 95) begin
        send_request(KIND_W'($urandom_range(KIND_STATUS, KIND_STATUS_ALT)), $urandom);
      end else begin
        send_request(KIND_GP0, $urandom);
      end
    end
    idle_enable = 1'b1;
    in_valid <= 1'b0;

    // Drain: wait for every predicted result, then go on watching for strays.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bus requests: packets, copies, control writes and status reads.",
             requests_sent);
    $display("%0d results checked, %0d flagged as unknown, %0d mismatches.",
             results_seen, flags_seen, mismatches);
    if (mismatches == 0) begin
      $display("gpu_command_port_status verification clean");
    end else begin
      $display("gpu_command_port_status verification failed");
    end
    $finish;
  end

endmodule
